// ----- hw/rtl/bup2_pkg.sv -----
// bup2_pkg: shared constants, pixel and job types, mean helpers for the
// bilinear 2x upscaler. No dependencies; every file but bup2_ram uses it.
`timescale 1ns / 1ps

package bup2_pkg;

  // field widths
  localparam int CHAN_W     = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COORD_W    = 11;
  localparam int ROW_W      = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // frame limits
  localparam int                    MAX_WIDTH_DEF = 1024;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_CAP    = 11'd1024;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // one classified input pixel, ready for the back end
  typedef struct packed {
    rgb_t               cur;
    rgb_t               mean_h;
    rgb_t               mean_v;
    rgb_t               mean_q;
    logic [COORD_W-1:0] col2;
    logic [COORD_W-1:0] row2;
    logic               has_left;
    logic               has_up;
  } job_t;

  // floored mean of two channels
  function automatic logic [CHAN_W-1:0] mean2(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CHAN_W:1];
  endfunction

  // floored mean of four channels
  function automatic logic [CHAN_W-1:0] mean4(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c,
                                              input logic [CHAN_W-1:0] d);
    logic [CHAN_W+1:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return sum[CHAN_W+1:2];
  endfunction

  function automatic rgb_t mean2_rgb(input rgb_t a, input rgb_t b);
    rgb_t m;
    m.red   = mean2(a.red, b.red);
    m.green = mean2(a.green, b.green);
    m.blue  = mean2(a.blue, b.blue);
    return m;
  endfunction

  function automatic rgb_t mean4_rgb(input rgb_t a, input rgb_t b, input rgb_t c,
                                     input rgb_t d);
    rgb_t m;
    m.red   = mean4(a.red, b.red, c.red, d.red);
    m.green = mean4(a.green, b.green, c.green, d.green);
    m.blue  = mean4(a.blue, b.blue, c.blue, d.blue);
    return m;
  endfunction

endpackage

// ----- hw/rtl/bup2_if.sv -----
// bup2_if: valid/ready channel interfaces for pixels in, results out and
// register writes. Depends on bup2_pkg for field widths.
`timescale 1ns / 1ps

// input pixel channel
interface bup2_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bup2_pkg::CHAN_W-1:0] pix_red;
  logic [bup2_pkg::CHAN_W-1:0] pix_green;
  logic [bup2_pkg::CHAN_W-1:0] pix_blue;

  modport source(output valid, pix_red, pix_green, pix_blue, input ready);
  modport sink(input valid, pix_red, pix_green, pix_blue, output ready);
endinterface

// result channel
interface bup2_res_if;
  logic                         valid;
  logic                         ready;
  logic [bup2_pkg::CHAN_W-1:0]  out_red;
  logic [bup2_pkg::CHAN_W-1:0]  out_green;
  logic [bup2_pkg::CHAN_W-1:0]  out_blue;
  logic [bup2_pkg::COORD_W-1:0] out_col;
  logic [bup2_pkg::COORD_W-1:0] out_row;
  logic                         run_last;

  modport source(output valid, out_red, out_green, out_blue, out_col, out_row, run_last,
                 input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_col, out_row, run_last,
               output ready);
endinterface

// register write channel
interface bup2_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bup2_pkg::CFG_IDX_W-1:0]  index;
  logic [bup2_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/bilinear_upscale_two.sv -----
// bilinear_upscale_two: top level of the streaming bilinear 2x upscaler.
// Depends on bup2_pkg, bup2_if, bup2_front, bup2_queue and bup2_back.
//
// Usage:
//   in_pix  takes RGB pixels of a frame in raster order, valid/ready.
//   out_res gives the enlarged pixels with out_col/out_row tags; each input
//           pixel makes one to four results, run_last marks its final one.
//           A frame store downstream puts them in place.
//   cfg_wr  writes image_width (index 0) and image_height (index 1); it is
//           always ready and should be used only while the block is idle.
// Flow:
//   a pixel's first result goes through the front stage, the job queue
//   and the output register. A pixel's results leave the single result
//   register one at a time (one at the frame origin, two elsewhere on the
//   first row or column, four inside the frame); the input keeps taking
//   requests meanwhile until the job queue and the stage fill.
// Reset (rst_n low, synchronous) restores 640 x 480 and the frame origin.
// The line buffer is not cleared: the first row fills it before use.
// When out_res stalls, results hold in the output register and the queue
// and stage fill, then in_pix.ready drops; nothing is lost.
`timescale 1ns / 1ps

module bilinear_upscale_two #(
  parameter int MAX_WIDTH = bup2_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bup2_pix_if.sink    in_pix,
  bup2_cfg_if.sink    cfg_wr,
  bup2_res_if.source  out_res
);

  import bup2_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // position tracking, line buffer and means
  bup2_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg_wr     (cfg_wr),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // decoupling queue
  bup2_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  // result sequencing
  bup2_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .out_res   (out_res)
  );

endmodule

// ----- hw/rtl/bup2_ram.sv -----
// bup2_ram: generic simple dual-port RAM, one write and one registered read
// port, read returns the old word on a same-address write. No dependencies.
`timescale 1ns / 1ps

module bup2_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bup2_front.sv -----
// bup2_front: configuration registers, raster position counters, line
// buffer and mean computation; turns each pixel into a job for the queue.
// Depends on bup2_pkg, bup2_if and bup2_ram.
`timescale 1ns / 1ps

module bup2_front #(
  parameter int MAX_WIDTH = bup2_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  bup2_pix_if.sink       in_pix,
  bup2_cfg_if.sink       cfg_wr,
  output logic           push_valid,
  output bup2_pkg::job_t push_job,
  input  logic           push_ready
);

  import bup2_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam logic [WW-1:0] WIDTH_LIM = WW'(MAX_WIDTH);

  // configuration
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;

  // raster position and neighbor pixels
  logic [CW-1:0]    col_r;
  logic [CW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  rgb_t             left_r;
  rgb_t             ul_r;

  // stage holding the pixel while its line-buffer word is read
  logic               s1_valid_r;
  rgb_t               s1_cur_r;
  rgb_t               s1_left_r;
  logic [COORD_W-1:0] s1_col2_r;
  logic [COORD_W-1:0] s1_row2_r;
  logic               s1_has_left_r;
  logic               s1_has_up_r;

  logic                  in_acc;
  logic                  push;
  rgb_t                  cur_pix;
  rgb_t                  above;
  logic [3*CHAN_W-1:0]   ram_rd_data;
  logic [WW-1:0]         w_ext;
  logic [WW-1:0]         w_eff;
  logic [WW-1:0]         col_inc;
  logic [CFG_DATA_W-1:0] h_eff;
  logic [CFG_DATA_W-1:0] row_ext;
  logic [CFG_DATA_W-1:0] row_inc;
  logic [CW:0]           col_dbl;

  assign cfg_wr.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr.data;
        REG_IMAGE_HEIGHT: height_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // handshake between input, stage and queue
  assign push          = s1_valid_r && push_ready;
  assign in_pix.ready  = !s1_valid_r || push_ready;
  assign in_acc        = in_pix.valid && in_pix.ready;
  assign push_valid    = s1_valid_r;

  assign cur_pix.red   = in_pix.pix_red;
  assign cur_pix.green = in_pix.pix_green;
  assign cur_pix.blue  = in_pix.pix_blue;

  // clamp frame size to the supported range
  always_comb begin
    w_ext = WW'(width_r);
    if (w_ext > WIDTH_LIM) begin
      w_eff = WIDTH_LIM;
    end else if (w_ext == '0) begin
      w_eff = WW'(1);
    end else begin
      w_eff = w_ext;
    end
    if (height_r > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end else if (height_r == '0) begin
      h_eff = CFG_DATA_W'(1);
    end else begin
      h_eff = height_r;
    end
  end

  // next raster position
  always_comb begin
    col_inc = WW'(col_r) + WW'(1);
    row_ext = CFG_DATA_W'(row_r);
    row_inc = row_ext + CFG_DATA_W'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = (row_ext >= h_eff) ? '0 : row_r;
    end
  end

  // line buffer: previous row, read and rewritten at the same column
  bup2_ram #(
    .WIDTH (3 * CHAN_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_r),
    .wr_data (cur_pix),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (ram_rd_data)
  );

  assign above = rgb_t'(ram_rd_data);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      ul_r       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        left_r     <= cur_pix;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push) begin
        ul_r <= above;
      end
    end
  end

  assign col_dbl = {col_r, 1'b0};

  // stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r      <= cur_pix;
      s1_left_r     <= left_r;
      s1_col2_r     <= COORD_W'(col_dbl);
      s1_row2_r     <= {row_r, 1'b0};
      s1_has_left_r <= (col_r != '0);
      s1_has_up_r   <= (row_r != '0);
    end
  end

  // job with all candidate output colors
  always_comb begin
    push_job.cur      = s1_cur_r;
    push_job.mean_h   = mean2_rgb(s1_cur_r, s1_left_r);
    push_job.mean_v   = mean2_rgb(s1_cur_r, above);
    push_job.mean_q   = mean4_rgb(s1_cur_r, above, s1_left_r, ul_r);
    push_job.col2     = s1_col2_r;
    push_job.row2     = s1_row2_r;
    push_job.has_left = s1_has_left_r;
    push_job.has_up   = s1_has_up_r;
  end

endmodule

// ----- hw/rtl/bup2_queue.sv -----
// bup2_queue: short job queue between the front and back ends.
// Depends on bup2_pkg for the job type and depth.
`timescale 1ns / 1ps

module bup2_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  bup2_pkg::job_t push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output bup2_pkg::job_t pop_job,
  input  logic           pop_ready
);

  import bup2_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QW:0]   FULL_CNT = (QW + 1)'(QUEUE_DEPTH);
  localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r;
  logic [QW-1:0] rd_ptr_r;
  logic [QW:0]   count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + QW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + QW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QW + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/bup2_back.sv -----
// bup2_back: walks each queued job through its own copy, left, upper and
// corner results, skipping those it lacks, one per cycle unless out_res
// stalls, into the output register. Depends on bup2_pkg and bup2_if.
`timescale 1ns / 1ps

module bup2_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  input  bup2_pkg::job_t pop_job,
  output logic           pop_ready,
  bup2_res_if.source     out_res
);

  import bup2_pkg::*;

  typedef enum logic [1:0] {
    K_OWN,
    K_LEFT,
    K_UP,
    K_QUAD
  } kind_t;

  kind_t              kind_r;
  kind_t              kind_nxt;
  logic               last;
  logic               load;
  logic               take;
  rgb_t               pix;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;

  logic               out_valid_r;
  rgb_t               out_pix_r;
  logic [COORD_W-1:0] out_col_r;
  logic [COORD_W-1:0] out_row_r;
  logic               run_last_r;

  assign load      = !out_valid_r || out_res.ready;
  assign take      = load && pop_valid;
  assign pop_ready = take && last;

  // next result kind for this job, skipping the ones it does not have
  always_comb begin
    kind_nxt = K_OWN;
    last     = 1'b1;
    unique case (kind_r)
      K_OWN: begin
        if (pop_job.has_left) begin
          kind_nxt = K_LEFT;
          last     = 1'b0;
        end else if (pop_job.has_up) begin
          kind_nxt = K_UP;
          last     = 1'b0;
        end
      end
      K_LEFT: begin
        if (pop_job.has_up) begin
          kind_nxt = K_UP;
          last     = 1'b0;
        end
      end
      K_UP: begin
        if (pop_job.has_left) begin
          kind_nxt = K_QUAD;
          last     = 1'b0;
        end
      end
      K_QUAD: begin
        last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // color and coordinates of the current result
  always_comb begin
    unique case (kind_r)
      K_OWN: begin
        pix = pop_job.cur;
        col = pop_job.col2;
        row = pop_job.row2;
      end
      K_LEFT: begin
        pix = pop_job.mean_h;
        col = pop_job.col2 - COORD_W'(1);
        row = pop_job.row2;
      end
      K_UP: begin
        pix = pop_job.mean_v;
        col = pop_job.col2;
        row = pop_job.row2 - COORD_W'(1);
      end
      K_QUAD: begin
        pix = pop_job.mean_q;
        col = pop_job.col2 - COORD_W'(1);
        row = pop_job.row2 - COORD_W'(1);
      end
      default: begin
        pix = pop_job.cur;
        col = pop_job.col2;
        row = pop_job.row2;
      end
    endcase
  end

  // result sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= K_OWN;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= pop_valid;
      end
      if (take) begin
        kind_r     <= last ? K_OWN : kind_nxt;
        out_pix_r  <= pix;
        out_col_r  <= col;
        out_row_r  <= row;
        run_last_r <= last;
      end
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.out_red   = out_pix_r.red;
  assign out_res.out_green = out_pix_r.green;
  assign out_res.out_blue  = out_pix_r.blue;
  assign out_res.out_col   = out_col_r;
  assign out_res.out_row   = out_row_r;
  assign out_res.run_last  = run_last_r;

endmodule
